[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ita_pkg.sv]
`timescale 1ns / 1ps
package ita_pkg;

    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BYTE = 2'd3
    } t_op;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_A     = 8'h41;

    // One formatting job, as classified by the front part.
    typedef struct packed {
        logic        sign;  // emit '-' first
        logic        hex;   // hex digits, otherwise decimal
        logic [2:0]  pos;   // index of the leading digit
        logic [15:0] mag;   // magnitude to print
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_A + {4'd0, nib - 4'd10};
        end
        return c;
    endfunction

    function automatic logic [16:0] dec_pow(input logic [2:0] pos);
        logic [16:0] p;
        case (pos)
            3'd0: p = 17'd1;
            3'd1: p = 17'd10;
            3'd2: p = 17'd100;
            3'd3: p = 17'd1000;
            3'd4: p = 17'd10000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

endpackage

[rtl/ita_in_if.sv]
`timescale 1ns / 1ps
interface ita_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

[rtl/ita_out_if.sv]
`timescale 1ns / 1ps
interface ita_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

[rtl/ita_front.sv]
`timescale 1ns / 1ps
module ita_front (
    ita_in_if.sink         i_in,
    input  logic           i_full,
    output ita_pkg::t_push o_push
);
    import ita_pkg::*;

    t_op         op;
    logic        neg;
    logic [15:0] mag;
    logic [2:0]  pos;
    logic        hex;

    assign i_in.ready = !i_full;

    always_comb begin
        op  = t_op'(i_in.op);
        neg = (op == OP_SDEC) && i_in.value[15];
        mag = neg ? (16'd0 - i_in.value) : i_in.value;
        hex = 1'b0;
        pos = 3'd0;
        case (op)
            OP_UDEC, OP_SDEC: begin
                if (mag >= 16'd10000)     pos = 3'd4;
                else if (mag >= 16'd1000) pos = 3'd3;
                else if (mag >= 16'd100)  pos = 3'd2;
                else if (mag >= 16'd10)   pos = 3'd1;
                else                      pos = 3'd0;
            end
            OP_HEX: begin
                hex = 1'b1;
                if (mag > 16'h0FFF)      pos = 3'd3;
                else if (mag > 16'h00FF) pos = 3'd2;
                else if (mag > 16'h000F) pos = 3'd1;
                else                     pos = 3'd0;
            end
            default: begin
                // byte dump: always two digits of the low byte
                hex = 1'b1;
                mag = {8'd0, i_in.value[7:0]};
                pos = 3'd1;
            end
        endcase
    end

    always_comb begin
        o_push.valid    = i_in.valid;
        o_push.job.sign = neg;
        o_push.job.hex  = hex;
        o_push.job.pos  = pos;
        o_push.job.mag  = mag;
    end

endmodule

[rtl/ita_queue.sv]
`timescale 1ns / 1ps
module ita_queue #(
    parameter int P_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ita_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output ita_pkg::t_head o_head
);
    import ita_pkg::*;

    localparam int W_PTR = $clog2(P_DEPTH);
    localparam int W_CNT = $clog2(P_DEPTH + 1);

    t_job             r_mem [P_DEPTH];
    logic [W_PTR-1:0] r_wp, n_wp;
    logic [W_PTR-1:0] r_rp, n_rp;
    logic [W_CNT-1:0] r_cnt, n_cnt;
    logic             wr;
    logic             rd;

    assign o_full       = (r_cnt == W_CNT'(P_DEPTH));
    assign wr           = i_push.valid && !o_full;
    assign rd           = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr) begin
            n_wp = (r_wp == W_PTR'(P_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd) begin
            n_rp = (r_rp == W_PTR'(P_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_push.job;
        end
    end

endmodule

[rtl/ita_back.sv]
`timescale 1ns / 1ps
module ita_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ita_pkg::t_head i_head,
    output logic           o_pop,
    ita_out_if.source      o_out
);
    import ita_pkg::*;

    logic        r_job_v, n_job_v;
    logic        r_sign, n_sign;
    logic        r_hex, n_hex;
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_rem, n_rem;
    logic        r_ov, n_ov;
    logic [7:0]  r_ch, n_ch;
    logic        r_last, n_last;

    logic        adv;
    logic        emit;
    logic        last_c;
    logic        load;
    logic [7:0]  ch_c;
    logic [3:0]  nib;
    logic [3:0]  dig;
    logic [16:0] sub;

    assign adv    = !r_ov || o_out.ready;
    assign emit   = adv && r_job_v;
    assign last_c = !r_sign && (r_pos == 3'd0);
    assign load   = !r_job_v || (emit && last_c);
    assign o_pop  = load && i_head.valid;

    // decimal digit: largest multiple of the current power of ten that fits
    always_comb begin
        logic [16:0] mult;
        dig = 4'd0;
        sub = 17'd0;
        for (int d = 1; d <= 9; d++) begin
            mult = dec_pow(r_pos) * 17'(d);
            if ({1'b0, r_rem} >= mult) begin
                dig = 4'(d);
                sub = mult;
            end
        end
    end

    always_comb begin
        nib = 4'(r_rem >> {r_pos[1:0], 2'b00});
        if (r_sign) begin
            ch_c = CH_MINUS;
        end else if (r_hex) begin
            ch_c = hex_char(nib);
        end else begin
            ch_c = CH_ZERO + {4'd0, dig};
        end
    end

    always_comb begin
        n_job_v = r_job_v;
        n_sign  = r_sign;
        n_hex   = r_hex;
        n_pos   = r_pos;
        n_rem   = r_rem;
        if (load) begin
            n_job_v = i_head.valid;
            n_sign  = i_head.job.sign;
            n_hex   = i_head.job.hex;
            n_pos   = i_head.job.pos;
            n_rem   = i_head.job.mag;
        end else if (emit) begin
            if (r_sign) begin
                n_sign = 1'b0;
            end else begin
                n_pos = r_pos - 3'd1;
                if (!r_hex) begin
                    n_rem = r_rem - sub[15:0];
                end
            end
        end
    end

    always_comb begin
        n_ov   = r_ov;
        n_ch   = r_ch;
        n_last = r_last;
        if (adv) begin
            n_ov   = emit;
            n_ch   = ch_c;
            n_last = last_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_job_v <= n_job_v;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sign <= n_sign;
        r_hex  <= n_hex;
        r_pos  <= n_pos;
        r_rem  <= n_rem;
        r_ch   <= n_ch;
        r_last <= n_last;
    end

    assign o_out.valid = r_ov;
    assign o_out.ch    = r_ch;
    assign o_out.last  = r_last;

endmodule

[rtl/integer_to_ascii_formatter_top.sv]
`timescale 1ns / 1ps
// Integer to ASCII formatter: each word on i_in carries a 16-bit value and a
// format (unsigned decimal, signed decimal, upper-case hex, two-digit byte
// dump); o_out returns its characters most significant first, one word per
// character, with last set on the final one. An item has 1 to 6 characters;
// while the receiver does not stall, the sustained rate is one character per
// cycle and back-to-back items follow with no gap; that figure is set by the
// output register, which takes one character a cycle. The first character of a
// word passes through the queue write at the accepting edge, then the job load,
// then the output register. Decimal digits come from a compare against the
// nine multiples of the current power of ten, one digit per cycle while the
// output is not stalled.
`include "assert_macros.svh"
module integer_to_ascii_formatter_top #(
    parameter int P_QUEUE_DEPTH = 2  // job queue entries, 2 or more
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ita_in_if.sink    i_in,
    ita_out_if.source o_out
);
    import ita_pkg::*;

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    // Front: classify the word, pick sign, magnitude and leading digit.
    ita_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    // Queue: decouple the input side from character generation.
    ita_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // Back: walk the digits and drive the output register.
    ita_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // Pop only a job that is present.
    `ASSERT_ALWAYS(a_pop_has_head, !pop || head.valid, "pop from empty queue")
    // A taken input word must reach the queue.
    `ASSERT_ALWAYS(a_accept_pushes, !(i_in.valid && i_in.ready) || (push.valid && !full),
        "accepted word not written")
    // Hold a stalled output word unchanged until it is taken.
    `ASSERT_NEXT(a_out_hold, o_out.valid && !o_out.ready,
        o_out.valid && $stable(o_out.ch) && $stable(o_out.last),
        "output word changed while stalled")

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import ita_pkg::*;

    // One expected character word on the output channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_word;

    logic clk = 1'b0;
    logic rst_n;

    ita_in_if  in_if ();
    ita_out_if out_if ();

    integer_to_ascii_formatter_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Characters still owed by the block, oldest first.
    t_char_word expected_chars[$];

    int words_sent    = 0;
    int chars_checked = 0;
    int err_count     = 0;

    // Idle and stall odds in percent, changed between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // 4 ns period: high for 2 ns, low for 2 ns.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort if the run hangs: far beyond the slowest legal run of about
    // 475 words x 6 characters, each waiting out long receiver stalls.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ASCII for one nibble, upper-case letters above nine.
    function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return 8'h41 + 8'(nib - 4'd10);
    endfunction

    // Work out the characters of one accepted word and queue them, with the
    // last mark on the final one.
    function automatic void predict_chars(input t_op op, input logic [15:0] val);
        logic [7:0]  chars[6];
        int          n;
        int unsigned mag;
        int unsigned pw[5];
        n = 0;
        mag = val;
        pw = '{10000, 1000, 100, 10, 1};
        case (op)
            OP_HEX: begin
                // drop leading zero nibbles but keep the units nibble
                for (int i = 3; i >= 0; i--) begin
                    if ((val >> (4 * i)) != 16'd0 || i == 0) begin
                        chars[n] = nibble_ascii(val[4 * i +: 4]);
                        n++;
                    end
                end
            end
            OP_BYTE: begin
                // high byte plays no part
                chars[0] = nibble_ascii(val[7:4]);
                chars[1] = nibble_ascii(val[3:0]);
                n = 2;
            end
            default: begin
                if (op == OP_SDEC && val[15]) begin
                    chars[0] = 8'h2D;
                    n = 1;
                    // magnitude of the two's complement value; 0x8000 -> 32768
                    mag = 32'h10000 - int'(val);
                end
                for (int i = 0; i < 5; i++) begin
                    if (mag >= pw[i] || i == 4) begin
                        chars[n] = 8'h30 + 8'((mag / pw[i]) % 10);
                        n++;
                    end
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            expected_chars.push_back('{ch: chars[i], last: (i == n - 1)});
        end
    endfunction

    // Offer one word, with random idle cycles in front of it. Valid is left
    // high on return: the next call or the drain decides at the next falling
    // edge whether it drops or carries a new word.
    task automatic send_word(input t_op op, input logic [15:0] val);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.value <= val;
        do @(posedge clk); while (!in_if.ready);
        predict_chars(op, val);
        words_sent++;
    endtask

    // Drop valid and hold off until every owed character has come back.
    task automatic drain_output();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge clk);
    endtask

    // Zero in every format: a lone '0' except byte dump, which gives "00".
    task automatic test_zero_values();
        send_word(OP_UDEC, 16'd0);
        send_word(OP_SDEC, 16'd0);
        send_word(OP_HEX,  16'd0);
        send_word(OP_BYTE, 16'd0);
    endtask

    // Unsigned digit-count steps from one to two and four to five, up to the full five digits.
    task automatic test_decimal_bounds();
        send_word(OP_UDEC, 16'd9);
        send_word(OP_UDEC, 16'd10);
        send_word(OP_UDEC, 16'd9999);
        send_word(OP_UDEC, 16'd10000);
        send_word(OP_UDEC, 16'hFFFF);
    endtask

    // Signed extremes, most negative value included, minus one and minus ten.
    task automatic test_signed_bounds();
        send_word(OP_SDEC, 16'h8000);
        send_word(OP_SDEC, 16'h7FFF);
        send_word(OP_SDEC, 16'hFFFF);
        send_word(OP_SDEC, 16'hFFF6);
    endtask

    // Hex digit count at the one-to-two and three-to-four boundaries, plus letter digits A-D and F.
    task automatic test_hex_bounds();
        send_word(OP_HEX, 16'h000F);
        send_word(OP_HEX, 16'h0010);
        send_word(OP_HEX, 16'h0FFF);
        send_word(OP_HEX, 16'h1000);
        send_word(OP_HEX, 16'hFFFF);
        send_word(OP_HEX, 16'hABCD);
    endtask

    // Byte dump must ignore a loaded high byte and keep a leading zero.
    task automatic test_byte_dump();
        send_word(OP_BYTE, 16'hFF00);
        send_word(OP_BYTE, 16'h00FF);
        send_word(OP_BYTE, 16'h5A0E);
    endtask

    // Random words under one idle/stall setting. Widths are drawn first so
    // that short numbers, and thus every digit count, turn up often.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        t_op         op;
        int          nbits;
        logic [15:0] val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            op    = t_op'($urandom_range(0, 3));
            nbits = $urandom_range(1, 16);
            val   = 16'($urandom) & (16'hFFFF >> (16 - nbits));
            // negate half the signed words so short negatives appear too
            if (op == OP_SDEC && $urandom_range(0, 1) == 1) begin
                val = -val;
            end
            send_word(op, val);
        end
        drain_output();
    endtask

    // Receiver: stall at random, decided at each falling edge.
    always @(negedge clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each character word taken at a rising edge with the oldest
    // one owed.
    always @(posedge clk) begin : char_check
        t_char_word want;
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("[%0t] unexpected character 0x%02h last=%0b",
                             $time, out_if.ch, out_if.last);
                end
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== out_if.ch || want.last !== out_if.last) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("[%0t] mismatch: expected ch=0x%02h last=%0b, got ch=0x%02h last=%0b",
                                 $time, want.ch, want.last, out_if.ch, out_if.last);
                    end
                end
            end
        end
    end

    initial begin
        // Hold every input at a known level from time zero.
        rst_n        = 1'b0;
        in_if.valid  = 1'b0;
        in_if.op     = OP_UDEC;
        in_if.value  = 16'd0;
        out_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed edges run back to back with no idling.
        test_zero_values();
        test_decimal_bounds();
        test_signed_bounds();
        test_hex_bounds();
        test_byte_dump();
        drain_output();

        // Random traffic over four handshake phases; each one drains fully
        // before the next starts.
        test_random_traffic(113, 0, 0);
        test_random_traffic(112, 77, 0);
        test_random_traffic(113, 0, 77);
        test_random_traffic(112, 38, 38);

        // Let the pipeline settle to catch stray characters.
        repeat (20) @(posedge clk);
        if (expected_chars.size() != 0) begin
            err_count++;
            $display("%0d characters never arrived", expected_chars.size());
        end

        $display("Run covered %0d words in all four formats, edges and random values,",
                 words_sent);
        $display("and %0d characters checked with and without sender idling and output stalls.",
                 chars_checked);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
